/* hw/rtl/acde_pkg.sv */
// Shared constants, types and codes for the alpha composite depth estimator.
`timescale 1ns / 1ps

package acde_pkg;

  localparam int SAMPLE_BITS = 16;
  localparam int OFFSET_BITS = 13;

  localparam int COV_BITS  = SAMPLE_BITS + 1;
  localparam int DSUM_BITS = SAMPLE_BITS + OFFSET_BITS + 1;
  localparam int WPROD_BITS = COV_BITS + 1 + OFFSET_BITS;
  localparam int CNT_BITS  = $clog2(DSUM_BITS + 1);
  localparam int CFG_BITS  = (SAMPLE_BITS > OFFSET_BITS) ? SAMPLE_BITS : OFFSET_BITS;
  localparam int IDX_BITS  = 3;
  localparam int IN_W      = ((SAMPLE_BITS + 7) / 8) * 8;
  localparam int OUT_W     = ((OFFSET_BITS + COV_BITS + 7) / 8) * 8;

  localparam logic [COV_BITS-1:0] ONE = {1'b1, {SAMPLE_BITS{1'b0}}};

  localparam logic signed [OFFSET_BITS-1:0] OMAX = {1'b0, {(OFFSET_BITS-1){1'b1}}};
  localparam logic signed [OFFSET_BITS-1:0] OMIN = {1'b1, {(OFFSET_BITS-1){1'b0}}};

  localparam logic [OFFSET_BITS-1:0] START_RST  = OFFSET_BITS'(-32);
  localparam logic [OFFSET_BITS-1:0] STOP_RST   = OFFSET_BITS'(480);
  localparam logic [OFFSET_BITS-1:0] STEP_RST   = OFFSET_BITS'(32);
  localparam logic [SAMPLE_BITS-1:0] LOW_RST    = SAMPLE_BITS'(30326);
  localparam logic [SAMPLE_BITS-1:0] HIGH_RST   = SAMPLE_BITS'(42405);
  localparam logic [OFFSET_BITS-1:0] BORDER_RST = OFFSET_BITS'(16);

  localparam logic [IDX_BITS-1:0] CFG_START  = 3'd0;
  localparam logic [IDX_BITS-1:0] CFG_STOP   = 3'd1;
  localparam logic [IDX_BITS-1:0] CFG_STEP   = 3'd2;
  localparam logic [IDX_BITS-1:0] CFG_LOW    = 3'd3;
  localparam logic [IDX_BITS-1:0] CFG_HIGH   = 3'd4;
  localparam logic [IDX_BITS-1:0] CFG_BORDER = 3'd5;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_OPAC,
    ST_MUL1,
    ST_MUL2,
    ST_ACC,
    ST_DEPTH,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic                 start;
    logic [COV_BITS-1:0]  rem0;
    logic [DSUM_BITS-1:0] num;
    logic [COV_BITS-1:0]  divisor;
    logic [CNT_BITS-1:0]  iters;
  } div_req_t;

  typedef struct packed {
    logic                 done;
    logic [DSUM_BITS-1:0] quot;
  } div_rsp_t;

endpackage

/* hw/rtl/acde_div.sv */
// Shared restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module acde_div import acde_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic                 busy;
  logic                 done;
  logic [CNT_BITS-1:0]  cnt;
  logic [COV_BITS-1:0]  rem;
  logic [COV_BITS-1:0]  dvs;
  logic [DSUM_BITS-1:0] num;
  logic [DSUM_BITS-1:0] quot;

  logic [COV_BITS:0]    trial;
  logic [COV_BITS:0]    diff;
  logic                 ge;

  always_comb begin
    trial = {rem, num[DSUM_BITS-1]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= req.iters;
        rem  <= req.rem0;
        dvs  <= req.divisor;
        num  <= req.num;
        quot <= '0;
      end else if (busy) begin
        rem  <= ge ? diff[COV_BITS-1:0] : trial[COV_BITS-1:0];
        num  <= {num[DSUM_BITS-2:0], 1'b0};
        quot <= {quot[DSUM_BITS-2:0], ge};
        cnt  <= cnt - 1'b1;
        if (cnt == CNT_BITS'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

/* hw/rtl/alpha_composite_depth_estimator_top.sv */
// Top level: front-to-back alpha compositing depth estimator.
// A sample that continues the ray goes through the 16-step opacity division in the shared
// divider; that division is skipped when the ramp needs none.
// A sample that ends the ray adds the 30-step depth division, and waits while the result
// register is full. A new sample is accepted only once the last one is through, even while a result waits.
// Synchronous reset restores the register defaults and starts a fresh ray.
`timescale 1ns / 1ps

module alpha_composite_depth_estimator_top import acde_pkg::*; (
  input  logic                clk,
  input  logic                rst,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [IN_W-1:0]     s_axis_tdata,   // sample_level
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [OUT_W-1:0]    m_axis_tdata,   // surface_depth, coverage
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [IDX_BITS-1:0] cfg_index,
  input  logic [CFG_BITS-1:0] cfg_data
);

  state_t st, st_next;

  logic signed [OFFSET_BITS-1:0] start_reg, stop_reg, step_reg, border_reg;
  logic [SAMPLE_BITS-1:0]        low_reg, high_reg;

  logic [SAMPLE_BITS-1:0]        sample;
  logic [COV_BITS-1:0]           op;
  logic [COV_BITS-1:0]           tr;
  logic [COV_BITS-1:0]           joint;
  logic signed [WPROD_BITS-1:0]  wprod;
  logic signed [DSUM_BITS-1:0]   dsum;
  logic signed [OFFSET_BITS-1:0] ray;
  logic signed [OFFSET_BITS-1:0] res_depth;
  logic [COV_BITS-1:0]           res_cov;
  logic signed [OFFSET_BITS-1:0] depth_hold;

  div_req_t req;
  div_rsp_t rsp;

  acde_div u_div (
    .clk (clk),
    .rst (rst),
    .req (req),
    .rsp (rsp)
  );

  logic                          neg;
  logic                          passed;
  logic signed [OFFSET_BITS:0]   nxt;
  logic                          ray_done;
  logic                          op_zero, op_one;
  logic [2*COV_BITS-1:0]         tprod;
  logic [COV_BITS-1:0]           cov;
  logic signed [DSUM_BITS-1:0]   dsum_src;
  logic [DSUM_BITS-1:0]          dsum_mag;
  logic signed [DSUM_BITS-1:0]   q_signed;
  logic signed [DSUM_BITS:0]     mean;
  logic                          in_acc, out_acc;

  assign cfg_ready     = 1'b1;
  assign s_axis_tready = (st == ST_IDLE);
  assign in_acc        = s_axis_tvalid && s_axis_tready;
  assign out_acc       = m_axis_tvalid && m_axis_tready;
  assign m_axis_tdata  = OUT_W'({res_cov, res_depth});

  always_comb begin
    neg      = step_reg[OFFSET_BITS-1];
    passed   = neg ? (ray < stop_reg) : (ray > stop_reg);
    nxt      = {ray[OFFSET_BITS-1], ray} + {step_reg[OFFSET_BITS-1], step_reg};
    ray_done = (step_reg == '0) ||
               (neg ? (nxt < $signed({stop_reg[OFFSET_BITS-1], stop_reg}))
                    : (nxt > $signed({stop_reg[OFFSET_BITS-1], stop_reg})));
    op_zero  = sample <= low_reg;
    op_one   = (high_reg <= low_reg) || (sample >= high_reg);
    tprod    = tr * op;
    cov      = ONE - tr;
    // last term of the ray lands in dsum at the same edge the division starts
    dsum_src = (st == ST_ACC) ? dsum + wprod[DSUM_BITS-1:0] : dsum;
    dsum_mag = dsum_src[DSUM_BITS-1] ? DSUM_BITS'(-dsum_src) : DSUM_BITS'(dsum_src);
    q_signed = dsum[DSUM_BITS-1] ? -$signed(rsp.quot) : $signed(rsp.quot);
    mean     = {q_signed[DSUM_BITS-1], q_signed} +
               (DSUM_BITS+1)'(border_reg);
  end

  always_comb begin
    st_next     = st;
    req.start   = 1'b0;
    req.rem0    = COV_BITS'(sample - low_reg);
    req.num     = '0;
    req.divisor = COV_BITS'(high_reg - low_reg);
    req.iters   = CNT_BITS'(SAMPLE_BITS);
    case (st)
      ST_IDLE: begin
        if (in_acc) st_next = ST_CHECK;
      end
      ST_CHECK: begin
        if (passed) begin
          req.start   = 1'b1;
          req.rem0    = '0;
          req.num     = dsum_mag;
          req.divisor = cov + 1'b1;
          req.iters   = CNT_BITS'(DSUM_BITS);
          st_next     = ST_DEPTH;
        end else if (op_zero || op_one) begin
          st_next = ST_MUL1;
        end else begin
          req.start = 1'b1;
          st_next   = ST_OPAC;
        end
      end
      ST_OPAC: begin
        if (rsp.done) st_next = ST_MUL1;
      end
      ST_MUL1: st_next = ST_MUL2;
      ST_MUL2: st_next = ST_ACC;
      ST_ACC: begin
        if (ray_done) begin
          req.start   = 1'b1;
          req.rem0    = '0;
          req.num     = dsum_mag;
          req.divisor = cov + 1'b1;
          req.iters   = CNT_BITS'(DSUM_BITS);
          st_next     = ST_DEPTH;
        end else begin
          st_next = ST_IDLE;
        end
      end
      ST_DEPTH: begin
        if (rsp.done) st_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!m_axis_tvalid || m_axis_tready) st_next = ST_IDLE;
      end
      default: st_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      st <= ST_IDLE;
    end else begin
      st <= st_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      start_reg  <= START_RST;
      stop_reg   <= STOP_RST;
      step_reg   <= STEP_RST;
      low_reg    <= LOW_RST;
      high_reg   <= HIGH_RST;
      border_reg <= BORDER_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_START:  start_reg  <= cfg_data[OFFSET_BITS-1:0];
        CFG_STOP:   stop_reg   <= cfg_data[OFFSET_BITS-1:0];
        CFG_STEP:   step_reg   <= cfg_data[OFFSET_BITS-1:0];
        CFG_LOW:    low_reg    <= cfg_data[SAMPLE_BITS-1:0];
        CFG_HIGH:   high_reg   <= cfg_data[SAMPLE_BITS-1:0];
        CFG_BORDER: border_reg <= cfg_data[OFFSET_BITS-1:0];
        default: ;
      endcase
    end
  end

  // ray state
  always_ff @(posedge clk) begin
    if (rst) begin
      tr   <= ONE;
      dsum <= '0;
      ray  <= START_RST;
    end else begin
      case (st)
        ST_MUL2: tr <= tr - joint;
        ST_ACC: begin
          dsum <= dsum + wprod[DSUM_BITS-1:0];
          if (!ray_done) ray <= nxt[OFFSET_BITS-1:0];
        end
        ST_FINISH: begin
          if (!m_axis_tvalid || m_axis_tready) begin
            tr   <= ONE;
            dsum <= '0;
            ray  <= start_reg;
          end
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) sample <= s_axis_tdata[SAMPLE_BITS-1:0];
    if (st == ST_CHECK) op <= op_zero ? '0 : ONE;
    if (st == ST_OPAC && rsp.done) op <= {1'b0, rsp.quot[SAMPLE_BITS-1:0]};
    if (st == ST_MUL1) joint <= tprod[SAMPLE_BITS +: COV_BITS];
    if (st == ST_MUL2) wprod <= $signed({1'b0, joint}) * ray;
    if (st == ST_DEPTH && rsp.done) begin
      if (mean > (DSUM_BITS+1)'(OMAX)) depth_hold <= OMAX;
      else if (mean < (DSUM_BITS+1)'(OMIN)) depth_hold <= OMIN;
      else depth_hold <= mean[OFFSET_BITS-1:0];
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else begin
      if (st == ST_FINISH && (!m_axis_tvalid || m_axis_tready)) begin
        m_axis_tvalid <= 1'b1;
        res_depth     <= depth_hold;
        res_cov       <= cov;
      end else if (out_acc) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

/* test/tb_alpha_composite_depth_estimator_top.sv */
// Testbench for the alpha composite depth estimator: directed and random rays, self-checking.
`timescale 1ns / 1ps

module tb_alpha_composite_depth_estimator_top;
  import acde_pkg::*;

  localparam int IDLE_GAP    = 80;
  localparam int HOLD_CYCLES = 300;

  typedef struct packed {
    logic signed [OFFSET_BITS-1:0] depth;
    logic [COV_BITS-1:0]           cov;
  } depth_result_t;

  logic                clk;
  logic                rst;
  logic                s_axis_tvalid;
  logic                s_axis_tready;
  logic [IN_W-1:0]     s_axis_tdata;
  logic                m_axis_tvalid;
  logic                m_axis_tready;
  logic [OUT_W-1:0]    m_axis_tdata;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [IDX_BITS-1:0] cfg_index;
  logic [CFG_BITS-1:0] cfg_data;

  alpha_composite_depth_estimator_top dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data)
  );

  // register shadows
  logic signed [OFFSET_BITS-1:0] start_r, stop_r, step_r, border_r;
  logic [SAMPLE_BITS-1:0]        low_r, high_r;

  // ray state
  longint transp;
  longint depth_acc;
  longint ray_pos;

  depth_result_t pending_depths[$];
  int err_count;
  int send_idle_pct;
  int recv_idle_pct;
  bit hold_start;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #6_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  task automatic report_mismatch(input string msg);
    err_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  function automatic void restart_ray();
    transp    = longint'(ONE);
    depth_acc = 0;
    ray_pos   = longint'(start_r);
  endfunction

  function automatic longint opacity_for(input logic [SAMPLE_BITS-1:0] lvl);
    longint q;
    if (lvl <= low_r) return 0;
    if (high_r <= low_r) return longint'(ONE);
    q = ((longint'(lvl) - longint'(low_r)) <<< SAMPLE_BITS) /
        (longint'(high_r) - longint'(low_r));
    return (q > longint'(ONE)) ? longint'(ONE) : q;
  endfunction

  function automatic void composite_sample(input logic [SAMPLE_BITS-1:0] lvl);
    longint stp, spn, nxt, joint, cov, mean;
    bit neg, past, fin;
    depth_result_t res;
    stp  = longint'(stop_r);
    spn  = longint'(step_r);
    neg  = (spn < 0);
    past = neg ? (ray_pos < stp) : (ray_pos > stp);
    fin  = 1'b1;
    if (!past) begin
      joint     = (transp * opacity_for(lvl)) >>> SAMPLE_BITS;
      depth_acc = depth_acc + joint * ray_pos;
      transp    = transp - joint;
      nxt       = ray_pos + spn;
      fin       = (spn == 0) || (neg ? (nxt < stp) : (nxt > stp));
      if (!fin) ray_pos = nxt;
    end
    if (fin) begin
      cov  = longint'(ONE) - transp;
      mean = depth_acc / (cov + 1) + longint'(border_r);
      if (mean > longint'(OMAX)) mean = longint'(OMAX);
      if (mean < longint'(OMIN)) mean = longint'(OMIN);
      res.depth = OFFSET_BITS'(mean);
      res.cov   = COV_BITS'(cov);
      pending_depths = {pending_depths, res};
      restart_ray();
    end
  endfunction

  // valid stays high after the item so back-to-back items need no second assignment
  task automatic send_sample(input logic [SAMPLE_BITS-1:0] lvl);
    while ($urandom_range(99) < send_idle_pct) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_W'(lvl);
    @(posedge clk);
    while (!s_axis_tready) @(posedge clk);
    composite_sample(lvl);
  endtask

  task automatic wait_idle();
    s_axis_tvalid <= 1'b0;
    while (pending_depths.size() != 0) @(posedge clk);
    repeat (IDLE_GAP) @(posedge clk);
  endtask

  // cfg_valid is left high; the caller lowers it after the last write
  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    case (idx)
      CFG_START:  start_r  = val[OFFSET_BITS-1:0];
      CFG_STOP:   stop_r   = val[OFFSET_BITS-1:0];
      CFG_STEP:   step_r   = val[OFFSET_BITS-1:0];
      CFG_LOW:    low_r    = val[SAMPLE_BITS-1:0];
      CFG_HIGH:   high_r   = val[SAMPLE_BITS-1:0];
      CFG_BORDER: border_r = val[OFFSET_BITS-1:0];
      default: ;
    endcase
  endtask

  task automatic apply_config(input int st, input int sp, input int sn,
                              input int lo, input int hi, input int bd);
    wait_idle();
    write_reg(CFG_START,  CFG_BITS'(st));
    write_reg(CFG_STOP,   CFG_BITS'(sp));
    write_reg(CFG_STEP,   CFG_BITS'(sn));
    write_reg(CFG_LOW,    CFG_BITS'(lo));
    write_reg(CFG_HIGH,   CFG_BITS'(hi));
    write_reg(CFG_BORDER, CFG_BITS'(bd));
    cfg_valid <= 1'b0;
  endtask

  function automatic int rand_offset();
    int v;
    v = int'($urandom_range(8191)) - 4096;
    return v;
  endfunction

  function automatic logic [SAMPLE_BITS-1:0] pick_level();
    case ($urandom_range(7))
      0: return '0;
      1: return '1;
      2: return low_r;
      3: return high_r;
      4, 5: begin
        if (high_r > low_r) return SAMPLE_BITS'($urandom_range(high_r, low_r));
        return SAMPLE_BITS'($urandom_range(65535));
      end
      default: return SAMPLE_BITS'($urandom_range(65535));
    endcase
  endfunction

  task automatic check_result(input logic [OUT_W-1:0] data);
    depth_result_t want;
    if (pending_depths.size() == 0) begin
      report_mismatch($sformatf("unexpected item %h", data));
      return;
    end
    want = pending_depths.pop_front();
    if (data[OFFSET_BITS-1:0] !== want.depth)
      report_mismatch($sformatf("surface_depth %0d, expected %0d",
                                $signed(data[OFFSET_BITS-1:0]), want.depth));
    if (data[OFFSET_BITS +: COV_BITS] !== want.cov)
      report_mismatch($sformatf("coverage %0d, expected %0d",
                                data[OFFSET_BITS +: COV_BITS], want.cov));
  endtask

  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready) check_result(m_axis_tdata);
  end

  // receiver: random stalls, or one long hold-off on request
  initial begin
    int hold_left;
    hold_left = 0;
    m_axis_tready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_start) begin
        hold_start = 1'b0;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  task automatic test_default_ray();
    send_sample('0);
    send_sample(SAMPLE_BITS'(30326));
    send_sample(SAMPLE_BITS'(36000));
    send_sample('1);
  endtask

  task automatic test_ray_past_stop();
    // offset already beyond stop, positive then negative direction
    apply_config(100, 0, 16, 30326, 42405, 16);
    send_sample('1);
    send_sample(SAMPLE_BITS'(40000));
    apply_config(-100, 200, -16, 1000, 2000, -5);
    send_sample('1);
    send_sample(SAMPLE_BITS'(1500));
  endtask

  task automatic test_zero_step_saturation();
    apply_config(4000, 4095, 0, 0, 65535, 4095);
    send_sample('1);
    send_sample('1);
    send_sample('0);
    send_sample(SAMPLE_BITS'(1));
    apply_config(-4096, 4095, 0, 0, 65535, -4096);
    send_sample('1);
    send_sample('1);
    send_sample(SAMPLE_BITS'(32768));
  endtask

  task automatic test_hard_threshold();
    apply_config(-4096, 4095, 4095, 30000, 30000, 0);
    send_sample(SAMPLE_BITS'(30000));
    send_sample(SAMPLE_BITS'(30001));
    send_sample('1);
    apply_config(-4096, 100, 4095, 50000, 20000, 0);
    send_sample(SAMPLE_BITS'(50001));
    send_sample(SAMPLE_BITS'(49999));
  endtask

  task automatic test_unknown_index();
    wait_idle();
    write_reg(IDX_BITS'(6), CFG_BITS'($urandom));
    write_reg(IDX_BITS'(7), CFG_BITS'($urandom));
    cfg_valid <= 1'b0;
    send_sample(SAMPLE_BITS'(60000));
    send_sample(SAMPLE_BITS'(12345));
  endtask

  task automatic test_output_backpressure();
    int saved;
    apply_config(rand_offset(), 4095, 0, 0, 65535, rand_offset());
    saved = send_idle_pct;
    send_idle_pct = 0;
    hold_start = 1'b1;
    repeat (12) send_sample(SAMPLE_BITS'($urandom_range(65535)));
    send_idle_pct = saved;
  endtask

  task automatic test_random_rays(input int n_cfg, input int per_cfg);
    int st, sp, sn, lo, hi, bd, k;
    for (int c = 0; c < n_cfg; c++) begin
      if (c < n_cfg / 3) begin
        send_idle_pct = 20; recv_idle_pct = 81;
      end else if (c < 2 * n_cfg / 3) begin
        send_idle_pct = 81; recv_idle_pct = 20;
      end else begin
        send_idle_pct = 0; recv_idle_pct = 0;
      end
      st = rand_offset();
      case ($urandom_range(9))
        0: sn = 0;
        1: sn = rand_offset();
        default: begin
          sn = $urandom_range(300, 1);
          if ($urandom_range(1)) sn = -sn;
        end
      endcase
      k  = $urandom_range(8);
      sp = st + sn * k;
      if (sp > 4095) sp = 4095;
      if (sp < -4096) sp = -4096;
      if ($urandom_range(9) == 0) sp = rand_offset();
      case ($urandom_range(5))
        0: begin lo = $urandom_range(65535); hi = lo; end
        1: begin lo = 0; hi = 65535; end
        2: begin lo = $urandom_range(65535); hi = $urandom_range(lo); end
        default: begin
          lo = $urandom_range(60000);
          hi = lo + $urandom_range(65535 - lo, 1);
        end
      endcase
      case ($urandom_range(4))
        0: bd = 4095;
        1: bd = -4096;
        default: bd = rand_offset();
      endcase
      apply_config(st, sp, sn, lo, hi, bd);
      repeat (per_cfg) send_sample(pick_level());
    end
  endtask

  initial begin
    err_count     = 0;
    hold_start    = 1'b0;
    send_idle_pct = 20;
    recv_idle_pct = 81;
    start_r  = START_RST;
    stop_r   = STOP_RST;
    step_r   = STEP_RST;
    low_r    = LOW_RST;
    high_r   = HIGH_RST;
    border_r = BORDER_RST;
    restart_ray();
    rst           <= 1'b1;
    s_axis_tvalid <= 1'b0;
    s_axis_tdata  <= '0;
    cfg_valid     <= 1'b0;
    cfg_index     <= '0;
    cfg_data      <= '0;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_default_ray();
    test_ray_past_stop();
    test_zero_step_saturation();
    test_hard_threshold();
    test_unknown_index();
    test_output_backpressure();
    test_random_rays(12, 33);

    wait_idle();
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

/* sim.f */
hw/rtl/acde_pkg.sv
hw/rtl/acde_div.sv
hw/rtl/alpha_composite_depth_estimator_top.sv
test/tb_alpha_composite_depth_estimator_top.sv
